// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define PSA_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define PSA_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Types, codes and sizes shared by the pool segment allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;

	localparam logic [1:0] STRAT_FIRST = 2'd0;
	localparam logic [1:0] STRAT_BEST  = 2'd1;
	localparam logic [1:0] STRAT_WORST = 2'd2;
	localparam logic [1:0] STRAT_NEXT  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOFIT   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_BADADDR = 3'd3;
	localparam logic [2:0] ST_ZERO    = 3'd4;

	localparam logic REG_STRATEGY = 1'b0;
	localparam logic REG_POOL     = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] req_size;
		logic [15:0] block_addr;
	} psa_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] alloc_addr;
		logic [15:0] free_bytes;
		logic [6:0]  hole_count;
		logic [15:0] largest_free;
	} psa_rsp_t;

	typedef struct packed {
		logic        taken;
		logic [15:0] start;
		logic [15:0] len;
	} psa_seg_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		psa_seg_t         data;
	} psa_wr_t;

endpackage

// File: src/psa_seg_ram.sv
// ----------------------------------------------------------------------------
// psa_seg_ram
// Segment table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psa_seg_ram
	import psa_pkg::*;
(
	input  logic             clk,
	input  psa_wr_t          wr,
	input  logic [IDX_W-1:0] raddr,
	output psa_seg_t         rdata
);

	psa_seg_t mem_q [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/pool_segment_allocator.sv
// ----------------------------------------------------------------------------
// pool_segment_allocator
// Byte pool allocator over an ordered segment table (first/best/worst/next).
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req) takes one command item: allocate,
//    free, or status query. rsp channel returns exactly one item per command
//    with the status code, the allocated offset and pool statistics.
//  - APB port: register 0 (addr 0) strategy, register 1 (addr 4) pool size.
//    Writing the pool size rebuilds the table as one free segment (an empty
//    table for size 0). Write only while no command is in flight.
//  - One command at a time. With n table entries the block runs a scan of
//    n reads (placement or address lookup), then for a split or merge a
//    table shift of up to n moves, then a statistics scan of n reads.
//    All passes go through the single table read port, one entry a cycle.
//  - req_ready is high only while idle. The result sits in an output
//    register; a stalled receiver holds it there, and the next command
//    may be accepted meanwhile but waits at its end until the slot frees.
//  - Reset: the initial segment is written in S_INIT, then ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pool_segment_allocator
	import psa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  psa_req_t    req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output psa_rsp_t    rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// sequencer states
	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_SHUP   = 4'd4;
	localparam logic [3:0] S_SPLIT1 = 4'd5;
	localparam logic [3:0] S_SPLIT2 = 4'd6;
	localparam logic [3:0] S_FRD1   = 4'd7;
	localparam logic [3:0] S_FRD2   = 4'd8;
	localparam logic [3:0] S_FRD3   = 4'd9;
	localparam logic [3:0] S_FMERGE = 4'd10;
	localparam logic [3:0] S_SHDN   = 4'd11;
	localparam logic [3:0] S_STAT   = 4'd12;
	localparam logic [3:0] S_DONE   = 4'd13;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

	logic [3:0]       state_q;
	logic [1:0]       strat_q;
	logic [15:0]      pool_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] fc_q;
	logic [1:0]       cmd_q;
	logic [15:0]      req_q;
	logic [15:0]      blk_q;

	// table walk: issue counter, read-in-flight flag and its index
	logic [CNT_W-1:0] iss_q;
	logic             rv_q;
	logic [IDX_W-1:0] ridx_q;

	// chosen / located segment
	logic             found_q;
	logic [IDX_W-1:0] pick_q;
	logic [15:0]      pstart_q;
	logic [15:0]      plen_q;
	logic             ptaken_q;

	// neighbours for a free
	logic             nfree_q;
	logic [15:0]      nlen_q;
	logic             pvfree_q;
	logic [15:0]      pvstart_q;
	logic [15:0]      pvlen_q;

	logic [1:0]       dist_q;
	logic [CNT_W-1:0] cnt_new_q;

	logic [2:0]       status_q;
	logic [15:0]      addr_q;
	logic [15:0]      fb_q;
	logic [6:0]       holes_q;
	logic [15:0]      big_q;

	psa_rsp_t         rsp_q;
	logic             rsp_valid_q;

	psa_wr_t          wr;
	logic [IDX_W-1:0] raddr;
	psa_seg_t         rdata;

	logic             cfg_wr;
	logic             cfg_pool_wr;
	logic [IDX_W-1:0] base_idx;
	logic [CNT_W:0]   wsum;
	logic [CNT_W:0]   wrapped;
	logic [IDX_W-1:0] scan_idx;
	logic             use_wrap;
	logic             fits;
	logic             better;
	logic [CNT_W-1:0] pick_p1;
	logic [CNT_W-1:0] pick_p2;
	logic [CNT_W-1:0] fc_ext;
	logic [15:0]      merge_len;

	psa_seg_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	// APB
	assign pready      = 1'b1;
	assign cfg_wr      = psel & penable & pwrite;
	assign cfg_pool_wr = cfg_wr && (paddr[2] == REG_POOL);
	assign prdata      = (paddr[2] == REG_STRATEGY) ? {30'd0, strat_q} : {16'd0, pool_q};

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pick_p1 = CNT_W'(pick_q) + CNT_ONE;
	assign pick_p2 = CNT_W'(pick_q) + CNT_W'(2);
	assign fc_ext  = CNT_W'(fc_q);

	// next fit starts at the cursor and wraps round the table
	assign use_wrap = (state_q == S_SCAN) && (cmd_q == CMD_ALLOC) && (strat_q == STRAT_NEXT);
	assign base_idx = (use_wrap && (fc_ext < count_q)) ? fc_q : '0;
	assign wsum     = {1'b0, CNT_W'(base_idx)} + {1'b0, iss_q};
	assign wrapped  = (wsum >= {1'b0, count_q}) ? (wsum - {1'b0, count_q}) : wsum;
	assign scan_idx = wrapped[IDX_W-1:0];

	assign fits   = !rdata.taken && (rdata.len >= req_q);
	assign better = ((strat_q == STRAT_BEST) && (rdata.len < plen_q)) ||
	                ((strat_q == STRAT_WORST) && (rdata.len > plen_q));

	assign merge_len = plen_q + (nfree_q ? nlen_q : 16'd0) + (pvfree_q ? pvlen_q : 16'd0);

	always_comb begin
		case (state_q)
			S_SHUP:  raddr = IDX_W'(iss_q - CNT_ONE);
			S_SHDN:  raddr = iss_q[IDX_W-1:0];
			S_FRD1:  raddr = pick_p1[IDX_W-1:0];
			S_FRD2:  raddr = pick_q - IDX_W'(1);
			default: raddr = scan_idx;
		endcase
	end

	always_comb begin
		wr = '0;
		case (state_q)
			S_INIT: begin
				wr.en   = 1'b1;
				wr.addr = '0;
				wr.data = '{taken: 1'b0, start: 16'd0, len: pool_q};
			end
			S_DECIDE: begin
				// exact fit: mark taken in place
				if (cmd_q == CMD_ALLOC && found_q && plen_q == req_q) begin
					wr.en   = 1'b1;
					wr.addr = pick_q;
					wr.data = '{taken: 1'b1, start: pstart_q, len: plen_q};
				end
			end
			S_SHUP: begin
				wr.en   = rv_q;
				wr.addr = ridx_q + IDX_W'(1);
				wr.data = rdata;
			end
			S_SPLIT1: begin
				wr.en   = 1'b1;
				wr.addr = pick_p1[IDX_W-1:0];
				wr.data = '{taken: 1'b0, start: pstart_q + req_q, len: plen_q - req_q};
			end
			S_SPLIT2: begin
				wr.en   = 1'b1;
				wr.addr = pick_q;
				wr.data = '{taken: 1'b1, start: pstart_q, len: req_q};
			end
			S_FMERGE: begin
				wr.en = 1'b1;
				if (pvfree_q) begin
					wr.addr = pick_q - IDX_W'(1);
					wr.data = '{taken: 1'b0, start: pvstart_q, len: merge_len};
				end else begin
					wr.addr = pick_q;
					wr.data = '{taken: 1'b0, start: pstart_q, len: merge_len};
				end
			end
			S_SHDN: begin
				wr.en   = rv_q;
				wr.addr = ridx_q - IDX_W'(dist_q);
				wr.data = rdata;
			end
			default: wr = '0;
		endcase
		// rebuilding the pool overrides
		if (cfg_pool_wr) begin
			wr.en   = 1'b1;
			wr.addr = '0;
			wr.data = '{taken: 1'b0, start: 16'd0, len: pwdata[15:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			strat_q     <= STRAT_FIRST;
			pool_q      <= 16'hFFFF;
			count_q     <= CNT_ONE;
			fc_q        <= '0;
			iss_q       <= '0;
			rv_q        <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// S_DONE reloads the slot itself
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q    <= req.cmd;
						req_q    <= req.req_size;
						blk_q    <= req.block_addr;
						found_q  <= 1'b0;
						iss_q    <= '0;
						rv_q     <= 1'b0;
						addr_q   <= 16'd0;
						fb_q     <= 16'd0;
						holes_q  <= 7'd0;
						big_q    <= 16'd0;
						status_q <= (req.cmd == CMD_ALLOC && req.req_size == 16'd0)
						            ? ST_ZERO : ST_OK;
						if (req.cmd == CMD_ALLOC && req.req_size == 16'd0) begin
							state_q  <= S_STAT;
						end else if (req.cmd == CMD_ALLOC || req.cmd == CMD_FREE) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_STAT;
						end
					end
				end
				S_SCAN: begin
					if (iss_q < count_q) begin
						iss_q  <= iss_q + CNT_ONE;
						rv_q   <= 1'b1;
						ridx_q <= scan_idx;
					end else begin
						rv_q <= 1'b0;
					end
					if (rv_q) begin
						if (cmd_q == CMD_ALLOC) begin
							if (fits && (!found_q || better)) begin
								found_q  <= 1'b1;
								pick_q   <= ridx_q;
								pstart_q <= rdata.start;
								plen_q   <= rdata.len;
							end
						end else if (!found_q && rdata.start == blk_q) begin
							found_q  <= 1'b1;
							pick_q   <= ridx_q;
							pstart_q <= rdata.start;
							plen_q   <= rdata.len;
							ptaken_q <= rdata.taken;
						end
					end
					if (iss_q == count_q && !rv_q) begin
						iss_q   <= '0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rv_q  <= 1'b0;
					if (cmd_q == CMD_ALLOC) begin
						if (!found_q) begin
							status_q <= ST_NOFIT;
							state_q  <= S_STAT;
						end else if (plen_q == req_q) begin
							addr_q  <= pstart_q;
							fc_q    <= (pick_p1 >= count_q) ? '0 : pick_p1[IDX_W-1:0];
							state_q <= S_STAT;
						end else if (count_q == CNT_MAX) begin
							status_q <= ST_FULL;
							state_q  <= S_STAT;
						end else begin
							iss_q   <= count_q;
							state_q <= S_SHUP;
						end
					end else if (!found_q || !ptaken_q) begin
						status_q <= ST_BADADDR;
						state_q  <= S_STAT;
					end else begin
						state_q <= S_FRD1;
					end
				end
				S_SHUP: begin
					// move entries pick+1 .. count-1 up by one, top first
					if (iss_q > pick_p1) begin
						iss_q  <= iss_q - CNT_ONE;
						rv_q   <= 1'b1;
						ridx_q <= IDX_W'(iss_q - CNT_ONE);
					end else begin
						rv_q <= 1'b0;
						if (!rv_q) begin
							state_q <= S_SPLIT1;
						end
					end
				end
				S_SPLIT1: begin
					state_q <= S_SPLIT2;
				end
				S_SPLIT2: begin
					count_q <= count_q + CNT_ONE;
					addr_q  <= pstart_q;
					fc_q    <= pick_p1[IDX_W-1:0];
					iss_q   <= '0;
					rv_q    <= 1'b0;
					state_q <= S_STAT;
				end
				S_FRD1: begin
					state_q <= S_FRD2;
				end
				S_FRD2: begin
					nfree_q <= (pick_p1 < count_q) && !rdata.taken;
					nlen_q  <= rdata.len;
					state_q <= S_FRD3;
				end
				S_FRD3: begin
					pvfree_q  <= (pick_q != '0) && !rdata.taken;
					pvstart_q <= rdata.start;
					pvlen_q   <= rdata.len;
					state_q   <= S_FMERGE;
				end
				S_FMERGE: begin
					rv_q <= 1'b0;
					if (nfree_q && pvfree_q) begin
						iss_q     <= pick_p2;
						dist_q    <= 2'd2;
						cnt_new_q <= count_q - CNT_W'(2);
						if (pick_p1 < fc_ext) begin
							fc_q <= ((CNT_W'(pick_q) < fc_ext - CNT_ONE)
							         ? fc_q - IDX_W'(2) : fc_q - IDX_W'(1));
						end else if (CNT_W'(pick_q) < fc_ext) begin
							fc_q <= fc_q - IDX_W'(1);
						end
						state_q <= S_SHDN;
					end else if (nfree_q) begin
						iss_q     <= pick_p2;
						dist_q    <= 2'd1;
						cnt_new_q <= count_q - CNT_ONE;
						if (pick_p1 < fc_ext) begin
							fc_q <= fc_q - IDX_W'(1);
						end
						state_q <= S_SHDN;
					end else if (pvfree_q) begin
						iss_q     <= pick_p1;
						dist_q    <= 2'd1;
						cnt_new_q <= count_q - CNT_ONE;
						if (CNT_W'(pick_q) < fc_ext) begin
							fc_q <= fc_q - IDX_W'(1);
						end
						state_q <= S_SHDN;
					end else begin
						iss_q   <= '0;
						state_q <= S_STAT;
					end
				end
				S_SHDN: begin
					// close the gap: entries move down by dist
					if (iss_q < count_q) begin
						iss_q  <= iss_q + CNT_ONE;
						rv_q   <= 1'b1;
						ridx_q <= iss_q[IDX_W-1:0];
					end else begin
						rv_q <= 1'b0;
						if (!rv_q) begin
							count_q <= cnt_new_q;
							iss_q   <= '0;
							state_q <= S_STAT;
						end
					end
				end
				S_STAT: begin
					if (iss_q < count_q) begin
						iss_q  <= iss_q + CNT_ONE;
						rv_q   <= 1'b1;
						ridx_q <= scan_idx;
					end else begin
						rv_q <= 1'b0;
					end
					if (rv_q && !rdata.taken) begin
						holes_q <= holes_q + 7'd1;
						fb_q    <= fb_q + rdata.len;
						if (rdata.len > big_q) begin
							big_q <= rdata.len;
						end
					end
					if (iss_q == count_q && !rv_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q <= '{status: status_q, alloc_addr: addr_q, free_bytes: fb_q,
						           hole_count: holes_q, largest_free: big_q};
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// configuration: the user must write only while idle; the block does not enforce it
			if (cfg_wr) begin
				if (paddr[2] == REG_STRATEGY) begin
					strat_q <= pwdata[1:0];
				end else begin
					pool_q  <= pwdata[15:0];
					count_q <= (pwdata[15:0] == 16'd0) ? '0 : CNT_ONE;
					fc_q    <= '0;
				end
			end
		end
	end

	`PSA_CHECK(a_count_bound, count_q <= CNT_MAX, "segment count above table depth")
	`PSA_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "item taken while busy")
	`PSA_IMPL(a_addr_zero_on_err, rsp_valid && rsp.status != ST_OK, rsp.alloc_addr == 16'd0,
		"offset reported on a failed command")
	`PSA_IMPL(a_idle_no_read, state_q == S_IDLE, !rv_q, "table read pending while idle")

endmodule
